@@ rtl/tatc_pkg.sv @@
// shared types, constants and table for the thermistor temperature converter
`timescale 1ns / 1ps
`default_nettype none

package tatc_pkg;

    // ntc table sizing
    localparam int TABLE_ENTRIES = 15;
    localparam int REAL_ENTRIES  = 15;
    localparam int USED_ENTRIES  = (TABLE_ENTRIES > REAL_ENTRIES) ? REAL_ENTRIES :
                                   ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam int IDX_W         = $clog2(REAL_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED_ENTRIES - 1);

    // apb
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // shared divider
    localparam int DIV_W = 48;
    localparam int DVS_W = 20;
    localparam int CNT_W = 6;

    // operand widths of the two divisions and the scaling steps
    localparam int PROD_W  = 24;
    localparam int RNUM_W  = 25;
    localparam int TMAG_W  = 27;
    localparam logic [CNT_W-1:0] CNT_R   = CNT_W'(RNUM_W);
    localparam logic [CNT_W-1:0] CNT_T   = CNT_W'(DIV_W);

    // divide by 1000 and by 1000000 as reciprocal multiplications,
    // exact over the operand ranges in use
    localparam int                MV_SHIFT  = 33;
    localparam int                MVQ_W     = 2*PROD_W - MV_SHIFT;
    localparam logic [PROD_W-1:0] MV_RECIP  = 24'd8589935;
    localparam int                DEG_RW    = 28;
    localparam int                DEG_SHIFT = 47;
    localparam logic [DEG_RW-1:0] DEG_RECIP = 28'd140737489;

    // arithmetic constants
    localparam logic [11:0]      DIVIDER_MV     = 12'd3300;
    localparam logic [13:0]      DIVIDER_OHMS   = 14'd10000;
    localparam logic [22:0]      DEG_STEP_MICRO = 23'd5000000;
    localparam logic [DIV_W-1:0] SAT_POS_MAG    = 48'd128000000;
    localparam logic [DIV_W-1:0] SAT_NEG_MAG    = 48'd129000000;

    // config reset values
    localparam logic [9:0]        GAIN_RESET   = 10'd377;
    localparam logic signed [7:0] OFFSET_RESET = 8'sd46;

    typedef enum logic [0:0] {
        REG_GAIN   = 1'b0,
        REG_OFFSET = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FAULT = 2'd1,
        STAT_SAT   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV,
        S_CHECK,
        S_DIV_R,
        S_WAIT_R,
        S_SEARCH,
        S_SEG,
        S_SCALE,
        S_DIV_T,
        S_WAIT_T,
        S_ROUND,
        S_DEG,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [9:0]        gain;
        logic signed [7:0] offset;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // ntc resistance in ohms every 5 degrees from 0 c
    function automatic logic [15:0] ntc_ohms(input logic [IDX_W-1:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd35820;
            4'd1:    v = 16'd27340;
            4'd2:    v = 16'd21020;
            4'd3:    v = 16'd16290;
            4'd4:    v = 16'd12720;
            4'd5:    v = 16'd10000;
            4'd6:    v = 16'd7921;
            4'd7:    v = 16'd6315;
            4'd8:    v = 16'd5067;
            4'd9:    v = 16'd4090;
            4'd10:   v = 16'd3319;
            4'd11:   v = 16'd2709;
            4'd12:   v = 16'd2222;
            4'd13:   v = 16'd1832;
            4'd14:   v = 16'd1518;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // table point k in millionths of a degree
    function automatic logic [26:0] deg_micro(input logic [IDX_W-1:0] k);
        return {{(27-IDX_W){1'b0}}, k} * {4'd0, DEG_STEP_MICRO};
    endfunction

endpackage

`default_nettype wire

@@ rtl/tatc_cfg.sv @@
// apb register file for adc gain and offset
`timescale 1ns / 1ps
`default_nettype none

module tatc_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tatc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tatc_pkg::DATA_W-1:0] pwdata,
    output logic      [tatc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output tatc_pkg::t_cfg                   o_cfg
);
    import tatc_pkg::*;

    logic [9:0]        r_gain;
    logic [9:0]        n_gain;
    logic signed [7:0] r_offset;
    logic signed [7:0] n_offset;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_comb begin
        n_gain   = r_gain;
        n_offset = r_offset;
        if (w_wr) begin
            case (w_idx)
                REG_GAIN:   n_gain   = pwdata[9:0];
                REG_OFFSET: n_offset = pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GAIN:   prdata = {22'd0, r_gain};
            REG_OFFSET: prdata = {24'd0, r_offset};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_offset <= OFFSET_RESET;
        end else begin
            r_gain   <= n_gain;
            r_offset <= n_offset;
        end
    end

    assign o_cfg.gain   = r_gain;
    assign o_cfg.offset = r_offset;

endmodule

`default_nettype wire

@@ rtl/tatc_div.sv @@
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module tatc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  tatc_pkg::t_div_req              i_req,
    input  wire logic [tatc_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [tatc_pkg::DVS_W-1:0] i_divisor,
    output tatc_pkg::t_div_sts              o_sts,
    output logic      [tatc_pkg::DIV_W-1:0] o_quot
);
    import tatc_pkg::*;

    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [DIV_W-1:0] r_dvd;
    logic [DIV_W-1:0] n_dvd;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] n_dvs;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // dividend is left aligned, quotient bits fill in from the bottom
    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.count;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DIV_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_dvd;

endmodule

`default_nettype wire

@@ rtl/thermistor_adc_to_temperature_top.sv @@
// top level: ntc thermistor adc reading to whole degrees celsius
`timescale 1ns / 1ps
`default_nettype none

// Converts one 14-bit thermistor adc count to a temperature in whole degrees
// celsius. The count is scaled to millivolts (gain * count / 1000 + offset,
// kept to 16 bits), turned into the resistance of a 10 kohm divider on
// 3300 mV, placed on a 15-point ntc table (0 C to 70 C in 5 degree steps)
// and interpolated linearly, truncating toward zero. Readings of 3300 mV or
// more (a negative sum included) return 0 with status 1; temperatures
// beyond -128..127 saturate with status 2. The divide by 1000 and the
// final millionths-to-degrees step are reciprocal multiplications; the
// resistance and the segment slope run one after another on a single
// restoring divider that makes one quotient bit per cycle (25 and 48 bits),
// and the table search examines one entry at a time (1 to 14). o_in_stall
// is high from acceptance until the result has been moved to the output
// register, so the next item is taken in the following cycle at the
// earliest; a finished result may wait there while the next item is already
// being taken in. Gain and offset sit on the apb port at byte addresses 0
// and 4 and should only be written while no item is in flight.

module thermistor_adc_to_temperature_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input item
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [13:0]                 i_raw_reading,
    // result item
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [7:0]                o_temperature_c,
    output logic      [1:0]                  o_status,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tatc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tatc_pkg::DATA_W-1:0] pwdata,
    output logic      [tatc_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import tatc_pkg::*;

    t_cfg             w_cfg;
    t_div_req         w_req;
    t_div_sts         w_sts;
    logic [DIV_W-1:0] w_dividend;
    logic [DVS_W-1:0] w_divisor;
    logic [DIV_W-1:0] w_quot;

    t_state           r_state;
    t_state           n_state;

    // working registers
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [MVQ_W-1:0]  r_mvq;
    logic [MVQ_W-1:0]  n_mvq;
    logic [RNUM_W-1:0] r_num;
    logic [RNUM_W-1:0] n_num;
    logic [11:0]       r_den;
    logic [11:0]       n_den;
    logic [RNUM_W-1:0] r_r;
    logic [RNUM_W-1:0] n_r;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [15:0]       r_d;
    logic [15:0]       n_d;
    logic              r_apos;
    logic              n_apos;
    logic [RNUM_W-1:0] r_amag;
    logic [RNUM_W-1:0] n_amag;
    logic [26:0]       r_y1;
    logic [26:0]       n_y1;
    logic [DIV_W-1:0]  r_scaled;
    logic [DIV_W-1:0]  n_scaled;
    logic              r_tneg;
    logic              n_tneg;
    logic [TMAG_W-1:0] r_tmag;
    logic [TMAG_W-1:0] n_tmag;
    logic [7:0]        r_temp;
    logic [7:0]        n_temp;
    t_status           r_stat;
    t_status           n_stat;

    // output register
    logic              r_out_valid;
    logic              n_out_valid;
    logic [7:0]        r_out_temp;
    logic [7:0]        n_out_temp;
    t_status           r_out_stat;
    t_status           n_out_stat;

    // combinational helpers
    logic              w_accept;
    logic              w_slot_free;
    logic [PROD_W-1:0] w_prod;
    logic [2*PROD_W-1:0] w_mv_prod;
    logic [15:0]       w_mv;
    logic              w_fault;
    logic [RNUM_W-1:0] w_num;
    logic [11:0]       w_den;
    logic [15:0]       w_x_cur;
    logic [15:0]       w_x_prev;
    logic [IDX_W-1:0]  w_idx_prev;
    logic              w_hit;
    logic [RNUM_W-1:0] w_x1_ext;
    logic [DIV_W-1:0]  w_y1_ext;
    logic [DIV_W-1:0]  w_scaled;
    logic              w_tneg;
    logic [DIV_W-1:0]  w_tmag;
    logic [TMAG_W+DEG_RW-1:0] w_deg_prod;
    logic [7:0]        w_deg_q;

    tatc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tatc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_sts),
        .o_quot     (w_quot)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // millivolts from count: product, divide by 1000 via reciprocal, add offset
    assign w_prod    = {14'd0, w_cfg.gain} * {10'd0, i_raw_reading};
    assign w_mv_prod = {{PROD_W{1'b0}}, r_prod} * {{PROD_W{1'b0}}, MV_RECIP};
    assign w_mv      = {{(16-MVQ_W){1'b0}}, r_mvq} + {{8{w_cfg.offset[7]}}, w_cfg.offset};
    assign w_fault   = (w_mv >= {4'd0, DIVIDER_MV});

    // divider network operands
    assign w_num = {13'd0, w_mv[11:0]} * {11'd0, DIVIDER_OHMS};
    assign w_den = DIVIDER_MV - w_mv[11:0];

    // table search: first entry below r, else the last segment
    assign w_idx_prev = r_idx - 1'b1;
    assign w_x_cur    = ntc_ohms(r_idx);
    assign w_x_prev   = ntc_ohms(w_idx_prev);
    assign w_hit      = (r_r > {9'd0, w_x_cur}) || (r_idx == LAST_IDX);
    assign w_x1_ext   = {9'd0, w_x_prev};

    assign w_scaled = {23'd0, r_amag} * {25'd0, DEG_STEP_MICRO};

    // whole degrees from the magnitude in millionths
    assign w_deg_prod = {{DEG_RW{1'b0}}, r_tmag} * {{TMAG_W{1'b0}}, DEG_RECIP};
    assign w_deg_q    = w_deg_prod[DEG_SHIFT +: 8];

    // t = y1 - sign(r - x1) * q, kept as sign and magnitude
    assign w_y1_ext = {21'd0, r_y1};
    always_comb begin
        if (r_apos) begin
            if (r_scaled > w_y1_ext) begin
                w_tneg = 1'b1;
                w_tmag = r_scaled - w_y1_ext;
            end else begin
                w_tneg = 1'b0;
                w_tmag = w_y1_ext - r_scaled;
            end
        end else begin
            w_tneg = 1'b0;
            w_tmag = w_y1_ext + r_scaled;
        end
    end

    // divider request and operands
    always_comb begin
        w_req.start = 1'b0;
        w_req.count = '0;
        w_dividend  = '0;
        w_divisor   = '0;
        case (r_state)
            S_DIV_R: begin
                w_req.start = 1'b1;
                w_req.count = CNT_R;
                w_dividend  = {r_num, {(DIV_W-RNUM_W){1'b0}}};
                w_divisor   = {{(DVS_W-12){1'b0}}, r_den};
            end
            S_DIV_T: begin
                w_req.start = 1'b1;
                w_req.count = CNT_T;
                w_dividend  = r_scaled;
                w_divisor   = {{(DVS_W-16){1'b0}}, r_d};
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_accept) n_state = S_MV;
            S_MV:       n_state = S_CHECK;
            S_CHECK:    n_state = w_fault ? S_DONE : S_DIV_R;
            S_DIV_R:    n_state = S_WAIT_R;
            S_WAIT_R:   if (w_sts.done) n_state = S_SEARCH;
            S_SEARCH:   if (w_hit) n_state = S_SEG;
            S_SEG:      n_state = S_SCALE;
            S_SCALE:    n_state = S_DIV_T;
            S_DIV_T:    n_state = S_WAIT_T;
            S_WAIT_T:   if (w_sts.done) n_state = S_ROUND;
            S_ROUND: begin
                if ((!w_tneg && (w_tmag >= SAT_POS_MAG)) ||
                    (w_tneg && (w_tmag >= SAT_NEG_MAG))) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DEG;
                end
            end
            S_DEG:      n_state = S_DONE;
            S_DONE:     if (w_slot_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_prod      = r_prod;
        n_mvq       = r_mvq;
        n_num       = r_num;
        n_den       = r_den;
        n_r         = r_r;
        n_idx       = r_idx;
        n_d         = r_d;
        n_apos      = r_apos;
        n_amag      = r_amag;
        n_y1        = r_y1;
        n_scaled    = r_scaled;
        n_tneg      = r_tneg;
        n_tmag      = r_tmag;
        n_temp      = r_temp;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_temp  = r_out_temp;
        n_out_stat  = r_out_stat;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_prod = w_prod;
            end
            S_MV: begin
                n_mvq = w_mv_prod[MV_SHIFT +: MVQ_W];
            end
            S_CHECK: begin
                // divider fault covers a wrapped negative sum as well
                if (w_fault) begin
                    n_temp = 8'd0;
                    n_stat = STAT_FAULT;
                end else begin
                    n_num = w_num;
                    n_den = w_den;
                end
            end
            S_WAIT_R: begin
                if (w_sts.done) begin
                    n_r   = w_quot[RNUM_W-1:0];
                    n_idx = IDX_W'(1);
                end
            end
            S_SEARCH: begin
                if (!w_hit) n_idx = r_idx + 1'b1;
            end
            S_SEG: begin
                // segment from idx-1 to idx, table falls with temperature
                n_d    = w_x_prev - w_x_cur;
                n_apos = (r_r > w_x1_ext);
                n_amag = (r_r > w_x1_ext) ? (r_r - w_x1_ext) : (w_x1_ext - r_r);
                n_y1   = deg_micro(w_idx_prev);
            end
            S_SCALE: begin
                n_scaled = w_scaled;
            end
            S_WAIT_T: begin
                if (w_sts.done) n_scaled = w_quot;
            end
            S_ROUND: begin
                n_tneg = w_tneg;
                n_tmag = w_tmag[TMAG_W-1:0];
                if (!w_tneg && (w_tmag >= SAT_POS_MAG)) begin
                    n_temp = 8'h7f;
                    n_stat = STAT_SAT;
                end else if (w_tneg && (w_tmag >= SAT_NEG_MAG)) begin
                    n_temp = 8'h80;
                    n_stat = STAT_SAT;
                end
            end
            S_DEG: begin
                // truncation toward zero: negate the floor of the magnitude
                n_temp = r_tneg ? (8'd0 - w_deg_q) : w_deg_q;
                n_stat = STAT_OK;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_temp;
                    n_out_stat  = r_stat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_mvq      <= n_mvq;
        r_num      <= n_num;
        r_den      <= n_den;
        r_r        <= n_r;
        r_idx      <= n_idx;
        r_d        <= n_d;
        r_apos     <= n_apos;
        r_amag     <= n_amag;
        r_y1       <= n_y1;
        r_scaled   <= n_scaled;
        r_tneg     <= n_tneg;
        r_tmag     <= n_tmag;
        r_temp     <= n_temp;
        r_stat     <= n_stat;
        r_out_temp <= n_out_temp;
        r_out_stat <= n_out_stat;
    end

    assign o_out_valid     = r_out_valid;
    assign o_temperature_c = r_out_temp;
    assign o_status        = r_out_stat;

endmodule

`default_nettype wire

@@ dv/temperature_checker.sv @@
// checker for the thermistor temperature converter: predicts readings and compares results
`timescale 1ns / 1ps

module temperature_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [13:0]                   i_raw_reading,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic signed [7:0]             i_temperature_c,
    input  wire logic [1:0]                    i_status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tatc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tatc_pkg::DATA_W-1:0]   pwdata,
    input  wire logic                          pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import tatc_pkg::*;

    // table points in use, bounded to the real entries
    localparam int POINTS = (TABLE_ENTRIES > REAL_ENTRIES) ? REAL_ENTRIES :
                            ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
    localparam int NTC_OHMS [0:14] = '{
        35820, 27340, 21020, 16290, 12720, 10000, 7921, 6315,
        5067, 4090, 3319, 2709, 2222, 1832, 1518
    };
    localparam longint MICRO_PER_DEG = 1000000;
    localparam longint DEG_PER_POINT = 5;

    typedef struct packed {
        logic [13:0]       raw;
        logic signed [7:0] temperature_c;
        t_status           status;
    } t_reading_result;

    t_reading_result   expected_readings [$];
    logic [9:0]        gain_setting;
    logic signed [7:0] offset_setting;

    function automatic t_reading_result predict_reading(input logic [13:0] raw,
                                                        input logic [9:0] gain,
                                                        input logic signed [7:0] offset);
        t_reading_result res;
        longint          scaled;
        longint          ohms;
        longint          x1, x2, y1, y2, micro, whole;
        logic [15:0]     mv;
        int              seg;
        bit              found;
        res.raw           = raw;
        res.temperature_c = '0;
        res.status        = STAT_OK;
        scaled = (longint'(gain) * longint'(raw)) / 1000 + longint'(offset);
        mv     = scaled[15:0];
        // negative sums wrap high and land here too
        if (mv >= 16'd3300) begin
            res.status = STAT_FAULT;
            return res;
        end
        ohms  = (longint'(10000) * longint'(mv)) / (longint'(3300) - longint'(mv));
        seg   = POINTS - 1;
        found = 1'b0;
        for (int i = 1; i < POINTS; i++) begin
            if (!found && ohms > longint'(NTC_OHMS[i])) begin
                seg   = i;
                found = 1'b1;
            end
        end
        x1    = NTC_OHMS[seg-1];
        x2    = NTC_OHMS[seg];
        y1    = longint'(seg - 1) * DEG_PER_POINT * MICRO_PER_DEG;
        y2    = longint'(seg) * DEG_PER_POINT * MICRO_PER_DEG;
        micro = ((y2 - y1) * (ohms - x1)) / (x2 - x1) + y1;
        whole = micro / MICRO_PER_DEG;
        if (whole < -128) begin
            whole      = -128;
            res.status = STAT_SAT;
        end else if (whole > 127) begin
            whole      = 127;
            res.status = STAT_SAT;
        end
        res.temperature_c = whole[7:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want,
                                   input logic [13:0] raw);
        $display("[%0t] mismatch on %s: got %0d, want %0d (raw reading %0d)",
                 $realtime, what, got, want, raw);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_reading_result want;
        if (!i_rst_n) begin
            gain_setting   = GAIN_RESET;
            offset_setting = OFFSET_RESET;
            expected_readings.delete();
            o_fail_count   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr >> 2)
                    REG_GAIN:   gain_setting   = pwdata[9:0];
                    REG_OFFSET: offset_setting = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_readings.push_back(
                    predict_reading(i_raw_reading, gain_setting, offset_setting));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected item", int'(i_temperature_c), 0, '0);
                end else begin
                    want = expected_readings.pop_front();
                    if (i_temperature_c !== want.temperature_c) begin
                        report_mismatch("temperature_c", int'(i_temperature_c),
                                        int'(want.temperature_c), want.raw);
                    end
                    if (i_status !== want.status) begin
                        report_mismatch("status", int'(i_status), int'(want.status),
                                        want.raw);
                    end
                end
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

@@ dv/testbench.sv @@
// top of the testbench: clock, reset, stimulus, configuration and verdict
`timescale 1ns / 1ps

module testbench;
    import tatc_pkg::*;

    // run length guard, several times the slowest correct run
    localparam int CYCLE_LIMIT      = 1000000;
    // extra cycles after the last result
    localparam int DRAIN_CYCLES     = 200;
    // the receiver holds off this long once, at this result count
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 2500;
    // directed millivolt targets: table ends, an exact table point, extrapolation
    // above the first entry, the saturation edge and both sides of the fault limit
    localparam int DIRECTED_MV [0:14] = '{
        435, 480, 700, 1000, 1300, 1650, 2000, 2300, 2580, 2700,
        3100, 3174, 3200, 3299, 3300
    };

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [13:0]        i_raw_reading = '0;
    logic               i_out_stall   = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [7:0]  o_temperature_c;
    logic [1:0]         o_status;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;
    int                 cycles;

    // stimulus-side copy of the settings, only used to aim readings at millivolts
    int                 gain_now   = 377;
    int                 offset_now = 46;

    thermistor_adc_to_temperature_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_reading   (i_raw_reading),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_temperature_c (o_temperature_c),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // watches both channels and the register port, predicts and compares
    temperature_checker temp_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_raw_reading   (i_raw_reading),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_temperature_c (o_temperature_c),
        .i_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin : clock_gen
        forever #6 i_clk = ~i_clk;
    end

    // cycle counter guarding against a hung handshake
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // raw count whose scaled value lands on (or just above) the target millivolts
    function automatic logic [13:0] reading_for_mv(input int target_mv);
        int need;
        int raw;
        if (gain_now == 0) begin
            return 14'($urandom());
        end
        need = target_mv - offset_now;
        if (need <= 0) begin
            return '0;
        end
        raw = (need * 1000 + gain_now - 1) / gain_now;
        return (raw > 16383) ? 14'h3FFF : 14'(raw);
    endfunction

    // most often aimed at the table range, some near the fault limit, some raw noise
    function automatic logic [13:0] random_reading();
        case ($urandom_range(0, 4))
            0:       return 14'($urandom());
            1:       return reading_for_mv(int'($urandom_range(3600, 0)) - 200);
            2:       return reading_for_mv(int'($urandom_range(3320, 3150)));
            default: return reading_for_mv(int'($urandom_range(2750, 380)));
        endcase
    endfunction

    // offer one item after a random gap (none when calm), return at the edge that takes it
    task automatic offer_reading(input logic [13:0] raw, input bit calm);
        int   gap;
        logic stalled;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_reading <= raw;
        // the stall seen at the falling edge is the one the next rising edge sees
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    // sender goes quiet until every expected item has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // both registers, with junk in the unused upper bits
    task automatic set_config(input logic [9:0] gain, input logic signed [7:0] offset);
        write_register(REG_GAIN, {22'($urandom()), gain});
        // psel goes low between the two transfers
        @(posedge i_clk);
        write_register(REG_OFFSET, {24'($urandom()), offset});
        gain_now   = int'(gain);
        offset_now = int'(offset);
        @(posedge i_clk);
    endtask

    // one setting's worth of items: both raw extremes first, then random
    task automatic run_phase(input int count);
        offer_reading(14'd0, 1'b0);
        offer_reading(14'h3FFF, 1'b0);
        for (int i = 0; i < count; i++) begin
            // a back-to-back stretch every hundred items
            offer_reading(random_reading(), (i % 100) >= 40 && (i % 100) < 55);
        end
        wait_drained();
    endtask

    // result side: random hold-off per item, one long hold-off to fill the block
    initial begin : result_sink
        int   hold;
        int   taken;
        logic offered;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken == LONG_HOLD_AT) begin
                hold = LONG_HOLD_CYCLES;
            end else if ((taken % 100) >= 60 && (taken % 100) < 75) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 8);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                offered = o_out_valid;
                @(posedge i_clk);
            end while (!offered);
            taken++;
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items on the reset settings: bit patterns, then aimed targets
        offer_reading(14'd0, 1'b0);
        offer_reading(14'h3FFF, 1'b0);
        offer_reading(14'h2AAA, 1'b0);
        offer_reading(14'h1555, 1'b0);
        for (int i = 0; i < 15; i++) begin
            offer_reading(reading_for_mv(DIRECTED_MV[i]), 1'b0);
        end
        // sender pause until the pipeline is empty
        wait_drained();

        // reset settings, the long receiver hold-off falls in here
        run_phase(280);

        // extremes of gain and offset; raw 0 with offset -128 wraps negative
        set_config(10'd1023, 8'sd127);
        run_phase(120);
        set_config(10'd1, -8'sd128);
        run_phase(100);
        set_config(10'd1023, -8'sd128);
        run_phase(120);
        set_config(10'd1, 8'sd127);
        run_phase(100);
        // zero gain leaves mv at the offset
        set_config(10'd0, 8'sd0);
        run_phase(40);
        // random settings
        for (int p = 0; p < 4; p++) begin
            set_config(10'($urandom_range(1, 1023)), 8'($urandom()));
            run_phase(120);
        end
        set_config(GAIN_RESET, OFFSET_RESET);
        run_phase(80);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
